>>> rtl/be2_pkg.sv
// shared types and constants of the 2x2 binary erosion stream
// no dependencies; used by be2_res_fifo and binary_erosion_2x2_stream
`default_nettype none

package be2_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW        = 1;
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 1'd1;

  localparam int unsigned CfgW            = 10;
  localparam logic [CfgW-1:0] FrameWidthRst  = 10'd512;
  localparam logic [CfgW-1:0] FrameHeightRst = 10'd512;

  localparam int unsigned MaxWidthDefault = 512;
  localparam int unsigned SampleW         = 8;
  localparam int unsigned LevelW          = 8;
  localparam logic [LevelW-1:0] LevelHigh = 8'd255;
  localparam logic [LevelW-1:0] LevelLow  = 8'd0;

  // result queue depth, room for two pushes per transfer
  localparam int unsigned ResDepth = 4;

  typedef struct packed {
    logic hit;
    logic frame_end;
    logic run_last;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

`default_nettype wire

>>> rtl/be2_line_ram.sv
// one-bit line store of the previous row, synchronous read with registered read data
// write-to-read forwarding for the same entry; uses no package
`default_nettype none

module be2_line_ram #(
  parameter int unsigned Depth = 512,
  parameter int unsigned AddrW = 9
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic             wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic                  rdata_o
);

  logic mem_q [Depth];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // forward the word written in the same cycle
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/be2_res_fifo.sv
// result queue taking up to two results per cycle while room_o is high, giving one
// depends on be2_pkg for result_t, push_t and ResDepth
`default_nettype none

module be2_res_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire be2_pkg::push_t   push_i,
  output logic                  room_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output be2_pkg::result_t      out_data_o
);

  localparam int unsigned PtrW = $clog2(be2_pkg::ResDepth);
  localparam int unsigned CntW = PtrW + 1;

  be2_pkg::result_t entry_q [be2_pkg::ResDepth];
  logic [PtrW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic [PtrW-1:0] tail, tail_nx;
  logic            pop;

  assign pop     = out_valid_o && out_ready_i;
  assign tail    = head_q + count_q[PtrW-1:0];
  assign tail_nx = tail + PtrW'(1);

  always_comb begin
    head_d  = pop ? head_q + PtrW'(1) : head_q;
    count_d = count_q + CntW'(push_i.num) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      entry_q[tail] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      entry_q[tail_nx] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  assign room_o      = count_q <= CntW'(be2_pkg::ResDepth - 2);
  assign out_valid_o = count_q != '0;
  assign out_data_o  = entry_q[head_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(be2_pkg::ResDepth))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.num != 2'd0) |-> (count_q <= CntW'(be2_pkg::ResDepth - 2)))
    else $error("push into a full result queue");

endmodule

`default_nettype wire

>>> rtl/binary_erosion_2x2_stream.sv
// top level of the 2x2 binary erosion stream: raster counters, window bits, config
// depends on be2_pkg, be2_line_ram and be2_res_fifo
// a result is written into the result queue on the transfer of the input that causes it
// throughput: one pixel per cycle while the result queue has room; a last-column pixel
//   can cause two results that drain through a four-entry result queue
// the line store is read ahead at the next column, so no read bubble
// reset: counters and window bits clear, registers go to 512 x 512; line store not cleared
`default_nettype none

module binary_erosion_2x2_stream #(
  parameter int unsigned MaxWidth = be2_pkg::MaxWidthDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // configuration write channel
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [be2_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [be2_pkg::CfgW-1:0]   cfg_data_i,
  // pixel input
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [7:0]                 s_axis_tdata,  // [7:0] red_sample
  // result output
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // [7:0] level
  output logic                            m_axis_tuser,  // [0] frame_end
  output logic                            m_axis_tlast   // run_last
);

  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned RowW = be2_pkg::CfgW;
  // compare width wide enough for column + 1 and for the width register
  localparam int unsigned CmpW = (((ColW + 1) > be2_pkg::CfgW) ? (ColW + 1) : be2_pkg::CfgW) + 1;

  // configuration registers
  logic [be2_pkg::CfgW-1:0] width_q, height_q;

  // raster position and the two left-hand window bits
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            left_q, left_d;
  logic            above_left_q, above_left_d;

  logic            accept;
  logic            room;
  logic            above;       // line store bit for the current column
  logic            cur_bit;
  logic            last_col;
  logic            flush_row;
  logic [CmpW-1:0] width_eff, width_ext, col_inc;
  logic [RowW-1:0] height_eff;

  be2_pkg::push_t   push;
  be2_pkg::result_t res0, res1, head;
  logic             emit0, emit1;

  // config channel is always free: writes must land only while the block is idle; not enforced here
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= be2_pkg::FrameWidthRst;
      height_q <= be2_pkg::FrameHeightRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        be2_pkg::RegFrameWidth:  width_q  <= cfg_data_i;
        be2_pkg::RegFrameHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // width of zero acts as one, above the line store depth acts as the depth; height of zero acts as one
  always_comb begin
    width_ext = CmpW'(width_q);
    if (width_q == '0) begin
      width_eff = CmpW'(1);
    end else if (width_ext > CmpW'(MaxWidth)) begin
      width_eff = CmpW'(MaxWidth);
    end else begin
      width_eff = width_ext;
    end
    height_eff = (height_q == '0) ? RowW'(1) : height_q;
  end

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = room;

  assign col_inc   = CmpW'(col_q) + CmpW'(1);
  assign last_col  = col_inc >= width_eff;
  assign flush_row = row_q >= height_eff;
  // samples of the flush row count as zero
  assign cur_bit   = (s_axis_tdata != '0) && !flush_row;

  // result for the pixel up and to the left of the current one
  assign emit0 = accept && (row_q != '0) && (col_q != '0);
  // the last column of the row above is outside the window, always zero
  assign emit1 = accept && (row_q != '0) && last_col;

  always_comb begin
    res0.hit       = above_left_q & above & left_q & cur_bit;
    res0.frame_end = 1'b0;
    res0.run_last  = !last_col;
    res1.hit       = 1'b0;
    res1.frame_end = flush_row;
    res1.run_last  = 1'b1;
    push.num       = 2'(emit0) + 2'(emit1);
    push.first     = emit0 ? res0 : res1;
    push.second    = res1;
  end

  // raster counters and window bits
  always_comb begin
    col_d        = col_q;
    row_d        = row_q;
    left_d       = left_q;
    above_left_d = above_left_q;
    if (accept) begin
      if (last_col) begin
        col_d        = '0;
        row_d        = flush_row ? '0 : row_q + RowW'(1);
        left_d       = 1'b0;
        above_left_d = 1'b0;
      end else begin
        col_d        = col_q + ColW'(1);
        left_d       = cur_bit;
        above_left_d = above;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      left_q       <= 1'b0;
      above_left_q <= 1'b0;
    end else begin
      col_q        <= col_d;
      row_q        <= row_d;
      left_q       <= left_d;
      above_left_q <= above_left_d;
    end
  end

  // read ahead at the next column, write back the current bit
  be2_line_ram #(
    .Depth (MaxWidth),
    .AddrW (ColW)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_q),
    .wdata_i (cur_bit),
    .raddr_i (col_d),
    .rdata_o (above)
  );

  be2_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (head)
  );

  assign m_axis_tdata = head.hit ? be2_pkg::LevelHigh : be2_pkg::LevelLow;
  assign m_axis_tuser = head.frame_end;
  assign m_axis_tlast = head.run_last;

  // column position never runs past the line store
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < MaxWidth)
    else $error("column counter beyond line store");

  // frame end only ever comes on the last result of a transfer
  a_frame_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("frame end without run last");

  // the frame end result restarts the raster position
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit1 && flush_row) |=> ((row_q == '0) && (col_q == '0)))
    else $error("counters not cleared after frame end");

endmodule

`default_nettype wire
